// ===== rtl/ccrc_pkg.sv =====
package ccrc_pkg;

   // Default voxel grid limit per axis.
   localparam int MAX_VOXELS_PER_AXIS = 16;

   // Width of a voxel count register.
   localparam int CFG_W = 5;
   // Width of a cell coordinate or a cell grid side (at most 2*31+1).
   localparam int CW = 6;
   // Width of the product of two sides.
   localparam int S12_W = 2 * CW;
   // Smallest internal cell id width: covers the largest grid the registers allow.
   localparam int ID_W_MIN = 18;
   // Width of the external cell id fields.
   localparam int EXT_ID_W = 16;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_MOVE  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_OK           = 3'd0,
      STS_MISSING      = 3'd1,
      STS_NONINCIDENT  = 3'd2,
      STS_CODIM        = 3'd3,
      STS_NOT_FREE     = 3'd4,
      STS_PARENT_COUNT = 3'd5,
      STS_NOT_MAXIMAL  = 3'd6,
      STS_RANGE        = 3'd7
   } status_type;

   localparam logic [1:0] CSR_VOXELS_X = 2'd0;
   localparam logic [1:0] CSR_VOXELS_Y = 2'd1;
   localparam logic [1:0] CSR_VOXELS_Z = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_SETUP2,
      S_DISPATCH,
      S_LB1,
      S_LB2,
      S_LB3,
      S_LWRITE,
      S_RDF,
      S_RDP,
      S_CHKP,
      S_DIVGO,
      S_DIVWAIT,
      S_GEO,
      S_NADDR,
      S_NDATA,
      S_WRF,
      S_WRP
   } fsm_type;

endpackage

// ===== rtl/ccrc_div.sv =====
module ccrc_div #(
   parameter int IDW = ccrc_pkg::ID_W_MIN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [IDW-1:0]          dividend,
   input  logic [ccrc_pkg::CW-1:0] divisor,
   output logic                    done,
   output logic [IDW-1:0]          quotient,
   output logic [ccrc_pkg::CW-1:0] remainder
);

   localparam int CNT_W = $clog2(IDW + 1);

   logic [IDW-1:0]          quo_ff, quo_in;
   logic [ccrc_pkg::CW-1:0] rem_ff, rem_in;
   logic [ccrc_pkg::CW-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [ccrc_pkg::CW:0]   trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[IDW-1]};
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = ccrc_pkg::CW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[IDW-2:0], 1'b1};
         end else begin
            rem_in = trial[ccrc_pkg::CW-1:0];
            quo_in = {quo_ff[IDW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(IDW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/ccrc_store.sv =====
module ccrc_store #(
   parameter int DEPTH = 35937,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic [AW-1:0] addr,
   input  logic          we,
   input  logic          wdata,
   output logic          rdata
);

   logic mem [DEPTH];
   logic rdata_ff;

   // Single port, read data registered; a write returns the old bit.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cubical_collapse_replay_checker_top.sv =====
// Cell store and elementary collapse checker for a 3D cubical complex.
// Items enter on the command channel: an item is taken at a rising edge where
// start is high and busy is low. A load item with voxel_set marks the 27 cells
// of one voxel, a move item checks a face and parent pair and removes both if
// the pair is a valid elementary collapse, and a clear item empties the store.
// Each item gives one result: rsp_valid is high for exactly one cycle with
// rsp_status. The receiver cannot hold a result off; busy drops in the same
// cycle that the result is shown, so the next item may be taken right then.
// An unused request type gives an OK result. A move runs four serial divisions
// that turn the two cell ids into coordinates, and the single store port
// serialises the load cell writes and the neighbor reads.
// A clear item sweeps the store one cell per cycle.
// After reset the same sweep runs with busy high, and no result is given for it.
// The voxel count registers reset to 1 and are written through the csr_ port;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
module cubical_collapse_replay_checker_top #(
   parameter int MAX_VOXELS_PER_AXIS = ccrc_pkg::MAX_VOXELS_PER_AXIS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [3:0]                    req_voxel_x,
   input  logic [3:0]                    req_voxel_y,
   input  logic [3:0]                    req_voxel_z,
   input  logic                          req_voxel_set,
   input  logic [ccrc_pkg::EXT_ID_W-1:0] req_face_id,
   input  logic [ccrc_pkg::EXT_ID_W-1:0] req_parent_id,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [ccrc_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int CW         = ccrc_pkg::CW;
   localparam int CFG_W      = ccrc_pkg::CFG_W;
   localparam int S12_W      = ccrc_pkg::S12_W;
   localparam int CELL_SIDE  = 2 * MAX_VOXELS_PER_AXIS + 1;
   localparam int CELL_COUNT = CELL_SIDE * CELL_SIDE * CELL_SIDE;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int IDW        = (AW > ccrc_pkg::ID_W_MIN) ? AW : ccrc_pkg::ID_W_MIN;

   // Configuration registers.
   logic [CFG_W-1:0] cfg_x_ff, cfg_y_ff, cfg_z_ff;

   ccrc_pkg::fsm_type    state_ff, state_in;
   ccrc_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Latched item.
   logic [1:0]     type_ff, type_in;
   logic [3:0]     vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic           vset_ff, vset_in;
   logic [IDW-1:0] face_ff, face_in, parent_ff, parent_in;

   // Grid geometry for this item.
   logic [CFG_W-1:0] eff_ff [3];
   logic [CFG_W-1:0] eff_in [3];
   logic [CW-1:0]    side [3];
   logic [S12_W-1:0] s12_ff, s12_in;
   logic [IDW-1:0]   total_ff, total_in;

   // Load walk.
   logic [IDW-1:0] cur_ff, cur_in, jb_ff, jb_in, ib_ff, ib_in;
   logic [1:0]     li_ff, li_in, lj_ff, lj_in, lk_ff, lk_in;

   // Move checking.
   logic [CW-1:0]  fq_ff [3];
   logic [CW-1:0]  fq_in [3];
   logic [CW-1:0]  pq_ff [3];
   logic [CW-1:0]  pq_in [3];
   logic [IDW-1:0] tmp_ff, tmp_in;
   logic [1:0]     ph_ff, ph_in;
   logic           fbit_ff, fbit_in;
   logic [2:0]     nb_ff, nb_in;
   logic           scan_par_ff, scan_par_in;
   logic           found_ff, found_in;
   logic [IDW-1:0] nid_ff, nid_in;
   logic           clr_pend_ff, clr_pend_in;
   logic [AW-1:0]  cl_ff, cl_in;

   // Store and divider connections.
   logic          mem_we, mem_wdata, mem_rdata;
   logic [AW-1:0] mem_addr;
   logic          div_go, div_done;
   logic [IDW-1:0] div_dividend, div_quo;
   logic [CW-1:0]  div_divisor, div_rem;

   // Condition signals.
   logic           load_oob, move_oob, cl_last, load_last;
   logic           geo_bad, geo_codim;
   logic [1:0]     changed;
   logic [1:0]     axis;
   logic [CW-1:0]  ctr;
   logic [IDW-1:0] cid, stride, nb_id;
   logic           nb_ok, nb_end;

   function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > 32'(MAX_VOXELS_PER_AXIS)) begin
         r = CFG_W'(MAX_VOXELS_PER_AXIS);
      end
      return r;
   endfunction

   ccrc_store #(.DEPTH(CELL_COUNT), .AW(AW)) u_store (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   ccrc_div #(.IDW(IDW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // A side of the cell grid is 2n+1 for n voxels.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         side[a] = {eff_ff[a], 1'b1};
      end
   end

   // Conditions shared by the next-state and datapath logic.
   always_comb begin
      load_oob = ({1'b0, vx_ff} >= eff_ff[0]) || ({1'b0, vy_ff} >= eff_ff[1]) ||
                 ({1'b0, vz_ff} >= eff_ff[2]);
      move_oob = (face_ff >= total_ff) || (parent_ff >= total_ff);
      cl_last  = (cl_ff == AW'(CELL_COUNT - 1));
      load_last = (li_ff == 2'd2) && (lj_ff == 2'd2) && (lk_ff == 2'd2);

      // Incidence: every differing axis must step from an odd parent
      // coordinate to an even face coordinate by exactly one.
      geo_bad = 1'b0;
      changed = '0;
      for (int a = 0; a < 3; a++) begin
         if (fq_ff[a] != pq_ff[a]) begin
            changed = changed + 1'b1;
            if (!pq_ff[a][0] || fq_ff[a][0] ||
                !(({1'b0, fq_ff[a]} == {1'b0, pq_ff[a]} + 1'b1) ||
                  ({1'b0, pq_ff[a]} == {1'b0, fq_ff[a]} + 1'b1))) begin
               geo_bad = 1'b1;
            end
         end
      end
      geo_codim = (changed != 2'd1);

      // Neighbor scan: nb = 2*axis + direction, direction 1 is the plus side.
      nb_end = (nb_ff >= 3'd6);
      axis   = (nb_ff[2:1] == 2'd3) ? 2'd2 : nb_ff[2:1];
      ctr    = scan_par_ff ? pq_ff[axis] : fq_ff[axis];
      cid    = scan_par_ff ? parent_ff : face_ff;
      case (axis)
         2'd0:    stride = IDW'(s12_ff);
         2'd1:    stride = IDW'(side[2]);
         default: stride = IDW'(1);
      endcase
      nb_ok = !nb_end && !ctr[0] &&
              (nb_ff[0] ? ({1'b0, ctr} + 1'b1 < {1'b0, side[axis]}) : (ctr != '0));
      nb_id = nb_ff[0] ? cid + stride : cid - stride;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccrc_pkg::S_CLEAR:    if (cl_last) state_in = ccrc_pkg::S_IDLE;
         ccrc_pkg::S_IDLE:     if (start) state_in = ccrc_pkg::S_SETUP;
         ccrc_pkg::S_SETUP:    state_in = ccrc_pkg::S_SETUP2;
         ccrc_pkg::S_SETUP2:   state_in = ccrc_pkg::S_DISPATCH;
         ccrc_pkg::S_DISPATCH: begin
            case (type_ff)
               ccrc_pkg::REQ_LOAD:
                  state_in = (load_oob || !vset_ff) ? ccrc_pkg::S_IDLE : ccrc_pkg::S_LB1;
               ccrc_pkg::REQ_MOVE:
                  state_in = move_oob ? ccrc_pkg::S_IDLE : ccrc_pkg::S_RDF;
               ccrc_pkg::REQ_CLEAR: state_in = ccrc_pkg::S_CLEAR;
               default:             state_in = ccrc_pkg::S_IDLE;
            endcase
         end
         ccrc_pkg::S_LB1:    state_in = ccrc_pkg::S_LB2;
         ccrc_pkg::S_LB2:    state_in = ccrc_pkg::S_LB3;
         ccrc_pkg::S_LB3:    state_in = ccrc_pkg::S_LWRITE;
         ccrc_pkg::S_LWRITE: if (load_last) state_in = ccrc_pkg::S_IDLE;
         ccrc_pkg::S_RDF:    state_in = ccrc_pkg::S_RDP;
         ccrc_pkg::S_RDP:    state_in = ccrc_pkg::S_CHKP;
         ccrc_pkg::S_CHKP:
            state_in = (fbit_ff && mem_rdata) ? ccrc_pkg::S_DIVGO : ccrc_pkg::S_IDLE;
         ccrc_pkg::S_DIVGO:  state_in = ccrc_pkg::S_DIVWAIT;
         ccrc_pkg::S_DIVWAIT: begin
            if (div_done) begin
               state_in = (ph_ff == 2'd3) ? ccrc_pkg::S_GEO : ccrc_pkg::S_DIVGO;
            end
         end
         ccrc_pkg::S_GEO:
            state_in = (geo_bad || geo_codim) ? ccrc_pkg::S_IDLE : ccrc_pkg::S_NADDR;
         ccrc_pkg::S_NADDR: begin
            if (nb_end) begin
               if (scan_par_ff) begin
                  state_in = ccrc_pkg::S_WRF;
               end else if (!found_ff) begin
                  state_in = ccrc_pkg::S_IDLE;
               end
            end else if (nb_ok) begin
               state_in = ccrc_pkg::S_NDATA;
            end
         end
         ccrc_pkg::S_NDATA: begin
            if (mem_rdata && (scan_par_ff || (nid_ff != parent_ff))) begin
               state_in = ccrc_pkg::S_IDLE;
            end else begin
               state_in = ccrc_pkg::S_NADDR;
            end
         end
         ccrc_pkg::S_WRF: state_in = ccrc_pkg::S_WRP;
         ccrc_pkg::S_WRP: state_in = ccrc_pkg::S_IDLE;
         default:         state_in = ccrc_pkg::S_IDLE;
      endcase
   end

   // Datapath, store port, divider and result.
   always_comb begin
      type_in     = type_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      vz_in       = vz_ff;
      vset_in     = vset_ff;
      face_in     = face_ff;
      parent_in   = parent_ff;
      eff_in      = eff_ff;
      s12_in      = s12_ff;
      total_in    = total_ff;
      cur_in      = cur_ff;
      jb_in       = jb_ff;
      ib_in       = ib_ff;
      li_in       = li_ff;
      lj_in       = lj_ff;
      lk_in       = lk_ff;
      fq_in       = fq_ff;
      pq_in       = pq_ff;
      tmp_in      = tmp_ff;
      ph_in       = ph_ff;
      fbit_in     = fbit_ff;
      nb_in       = nb_ff;
      scan_par_in = scan_par_ff;
      found_in    = found_ff;
      nid_in      = nid_ff;
      clr_pend_in = clr_pend_ff;
      cl_in       = cl_ff;
      status_in   = status_ff;
      rsp_valid_in = 1'b0;
      mem_we      = 1'b0;
      mem_wdata   = 1'b0;
      mem_addr    = cl_ff;
      div_go      = 1'b0;
      div_dividend = face_ff;
      div_divisor  = side[2];

      case (state_ff)
         ccrc_pkg::S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = cl_ff;
            cl_in    = cl_ff + 1'b1;
            if (cl_last) begin
               cl_in        = '0;
               rsp_valid_in = clr_pend_ff;
               status_in    = ccrc_pkg::STS_OK;
               clr_pend_in  = 1'b0;
            end
         end
         ccrc_pkg::S_IDLE: begin
            if (start) begin
               type_in   = req_type;
               vx_in     = req_voxel_x;
               vy_in     = req_voxel_y;
               vz_in     = req_voxel_z;
               vset_in   = req_voxel_set;
               face_in   = IDW'(req_face_id);
               parent_in = IDW'(req_parent_id);
               eff_in[0] = eff_count(cfg_x_ff);
               eff_in[1] = eff_count(cfg_y_ff);
               eff_in[2] = eff_count(cfg_z_ff);
            end
         end
         ccrc_pkg::S_SETUP: begin
            s12_in = S12_W'(side[1]) * S12_W'(side[2]);
         end
         ccrc_pkg::S_SETUP2: begin
            total_in = IDW'(side[0]) * IDW'(s12_ff);
         end
         ccrc_pkg::S_DISPATCH: begin
            case (type_ff)
               ccrc_pkg::REQ_LOAD: begin
                  if (load_oob) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ccrc_pkg::STS_RANGE;
                  end else if (!vset_ff) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ccrc_pkg::STS_OK;
                  end
               end
               ccrc_pkg::REQ_MOVE: begin
                  if (move_oob) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ccrc_pkg::STS_MISSING;
                  end
               end
               ccrc_pkg::REQ_CLEAR: begin
                  clr_pend_in = 1'b1;
                  cl_in       = '0;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  status_in    = ccrc_pkg::STS_OK;
               end
            endcase
         end
         // Base id of the voxel's lowest corner cell.
         ccrc_pkg::S_LB1: begin
            cur_in = IDW'({vx_ff, 1'b0}) * IDW'(s12_ff);
         end
         ccrc_pkg::S_LB2: begin
            cur_in = cur_ff + IDW'({vy_ff, 1'b0}) * IDW'(side[2]);
         end
         ccrc_pkg::S_LB3: begin
            cur_in = cur_ff + IDW'({vz_ff, 1'b0});
            jb_in  = cur_ff + IDW'({vz_ff, 1'b0});
            ib_in  = cur_ff + IDW'({vz_ff, 1'b0});
            li_in  = '0;
            lj_in  = '0;
            lk_in  = '0;
         end
         ccrc_pkg::S_LWRITE: begin
            mem_we    = 1'b1;
            mem_wdata = 1'b1;
            mem_addr  = cur_ff[AW-1:0];
            if (lk_ff != 2'd2) begin
               cur_in = cur_ff + 1'b1;
               lk_in  = lk_ff + 1'b1;
            end else if (lj_ff != 2'd2) begin
               cur_in = jb_ff + IDW'(side[2]);
               jb_in  = jb_ff + IDW'(side[2]);
               lk_in  = '0;
               lj_in  = lj_ff + 1'b1;
            end else if (li_ff != 2'd2) begin
               cur_in = ib_ff + IDW'(s12_ff);
               jb_in  = ib_ff + IDW'(s12_ff);
               ib_in  = ib_ff + IDW'(s12_ff);
               lk_in  = '0;
               lj_in  = '0;
               li_in  = li_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               status_in    = ccrc_pkg::STS_OK;
            end
         end
         ccrc_pkg::S_RDF: begin
            mem_addr = face_ff[AW-1:0];
         end
         ccrc_pkg::S_RDP: begin
            mem_addr = parent_ff[AW-1:0];
            fbit_in  = mem_rdata;
         end
         ccrc_pkg::S_CHKP: begin
            ph_in = '0;
            if (!(fbit_ff && mem_rdata)) begin
               rsp_valid_in = 1'b1;
               status_in    = ccrc_pkg::STS_MISSING;
            end
         end
         ccrc_pkg::S_DIVGO: begin
            div_go = 1'b1;
            case (ph_ff)
               2'd0: begin
                  div_dividend = face_ff;
                  div_divisor  = side[2];
               end
               2'd1: begin
                  div_dividend = tmp_ff;
                  div_divisor  = side[1];
               end
               2'd2: begin
                  div_dividend = parent_ff;
                  div_divisor  = side[2];
               end
               default: begin
                  div_dividend = tmp_ff;
                  div_divisor  = side[1];
               end
            endcase
         end
         ccrc_pkg::S_DIVWAIT: begin
            if (div_done) begin
               ph_in = ph_ff + 1'b1;
               case (ph_ff)
                  2'd0: begin
                     tmp_in   = div_quo;
                     fq_in[2] = div_rem;
                  end
                  2'd1: begin
                     fq_in[0] = div_quo[CW-1:0];
                     fq_in[1] = div_rem;
                  end
                  2'd2: begin
                     tmp_in   = div_quo;
                     pq_in[2] = div_rem;
                  end
                  default: begin
                     pq_in[0] = div_quo[CW-1:0];
                     pq_in[1] = div_rem;
                  end
               endcase
            end
         end
         ccrc_pkg::S_GEO: begin
            nb_in       = '0;
            scan_par_in = 1'b0;
            found_in    = 1'b0;
            if (geo_bad) begin
               rsp_valid_in = 1'b1;
               status_in    = ccrc_pkg::STS_NONINCIDENT;
            end else if (geo_codim) begin
               rsp_valid_in = 1'b1;
               status_in    = ccrc_pkg::STS_CODIM;
            end
         end
         ccrc_pkg::S_NADDR: begin
            mem_addr = nb_id[AW-1:0];
            nid_in   = nb_id;
            if (nb_end) begin
               if (!scan_par_ff) begin
                  if (!found_ff) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ccrc_pkg::STS_PARENT_COUNT;
                  end
                  scan_par_in = 1'b1;
                  nb_in       = '0;
               end
            end else if (!nb_ok) begin
               nb_in = nb_ff + 1'b1;
            end
         end
         ccrc_pkg::S_NDATA: begin
            nb_in = nb_ff + 1'b1;
            if (mem_rdata) begin
               if (scan_par_ff) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ccrc_pkg::STS_NOT_MAXIMAL;
               end else if (nid_ff != parent_ff) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ccrc_pkg::STS_NOT_FREE;
               end else begin
                  found_in = 1'b1;
               end
            end
         end
         ccrc_pkg::S_WRF: begin
            mem_we   = 1'b1;
            mem_addr = face_ff[AW-1:0];
         end
         ccrc_pkg::S_WRP: begin
            mem_we       = 1'b1;
            mem_addr     = parent_ff[AW-1:0];
            rsp_valid_in = 1'b1;
            status_in    = ccrc_pkg::STS_OK;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccrc_pkg::S_CLEAR;
         cl_ff        <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_x_ff     <= CFG_W'(1);
         cfg_y_ff     <= CFG_W'(1);
         cfg_z_ff     <= CFG_W'(1);
      end else begin
         state_ff     <= state_in;
         cl_ff        <= cl_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               ccrc_pkg::CSR_VOXELS_X: cfg_x_ff <= csr_wdata;
               ccrc_pkg::CSR_VOXELS_Y: cfg_y_ff <= csr_wdata;
               ccrc_pkg::CSR_VOXELS_Z: cfg_z_ff <= csr_wdata;
               default:                cfg_x_ff <= cfg_x_ff;
            endcase
         end
      end
      status_ff   <= status_in;
      type_ff     <= type_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      vset_ff     <= vset_in;
      face_ff     <= face_in;
      parent_ff   <= parent_in;
      eff_ff      <= eff_in;
      s12_ff      <= s12_in;
      total_ff    <= total_in;
      cur_ff      <= cur_in;
      jb_ff       <= jb_in;
      ib_ff       <= ib_in;
      li_ff       <= li_in;
      lj_ff       <= lj_in;
      lk_ff       <= lk_in;
      fq_ff       <= fq_in;
      pq_ff       <= pq_in;
      tmp_ff      <= tmp_in;
      ph_ff       <= ph_in;
      fbit_ff     <= fbit_in;
      nb_ff       <= nb_in;
      scan_par_ff <= scan_par_in;
      found_ff    <= found_in;
      nid_ff      <= nid_in;
   end

   assign busy       = (state_ff != ccrc_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

`ifndef NO_ASSERTIONS
   // An item passes through setup and dispatch before its result, so results never come back to back.
   a_single_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // The store sweep after reset holds off new items.
   a_reset_sweep : assert property (@(posedge clock)
      $past(reset) && !reset |-> busy && !rsp_valid)
      else $error("block idle right after reset");
`endif

endmodule
